[hw/rtl/nrd_pkg.sv]
// Package for the 16-bit non-restoring divider.
// Holds the shared width constant; no dependencies.
`default_nettype none

package nrd_pkg;

	// Operand and result width of the divider
	localparam int NRD_WIDTH = 16;

endpackage : nrd_pkg

`default_nettype wire

[hw/rtl/nrd_if.sv]
// Valid/ready channel interfaces for the divider: operands in, results out.
// Depends on nrd_pkg for the default width.
`default_nettype none

interface nrd_in_if #(
	parameter int WIDTH = nrd_pkg::NRD_WIDTH
) ();
	logic             valid;
	logic             ready;
	logic [WIDTH-1:0] dividend;
	logic [WIDTH-1:0] divisor;

	modport source (output valid, dividend, divisor, input ready);
	modport sink   (input valid, dividend, divisor, output ready);
endinterface : nrd_in_if

interface nrd_out_if #(
	parameter int WIDTH = nrd_pkg::NRD_WIDTH
) ();
	logic             valid;
	logic             ready;
	logic [WIDTH-1:0] quotient;
	logic [WIDTH-1:0] remainder;

	modport source (output valid, quotient, remainder, input ready);
	modport sink   (input valid, quotient, remainder, output ready);
endinterface : nrd_out_if

`default_nettype wire

[hw/rtl/nonrestoring_divider_16.sv]
// Non-restoring divider top level: a chain of WIDTH step stages and a fix stage.
// Depends on nrd_pkg, nrd_if (nrd_in_if, nrd_out_if), nrd_step and nrd_fix.
//
// Usage:
//   req carries a dividend and a divisor; rsp returns quotient and remainder.
//   Both are valid/ready channels; a transfer happens when valid and ready are
//   both high at a rising edge of clk.
//   A req transfer passes one register stage per recurrence step, then one
//   stage for the corrective add, before it shows on rsp.valid. One operand
//   pair can enter every cycle unless a stalled rsp has filled the pipeline, so
//   sustained throughput is one division per cycle.
//   A zero divisor is not trapped; the steps run as usual.
//   Reset (arst_n low) clears every stage valid bit at once; items in flight
//   are dropped and the pipeline is empty afterwards.
//   When rsp.ready is low, the result is held and the stages behind it keep
//   filling; each stage is ready when it is empty or the stage after it is
//   ready, so bubbles close up. req.ready drops only when every stage holds
//   an item and the result waits.
`default_nettype none

module nonrestoring_divider_16 #(
	parameter int WIDTH = nrd_pkg::NRD_WIDTH
) (
	input  wire logic clk,
	input  wire logic arst_n,
	nrd_in_if.sink    req,
	nrd_out_if.source rsp
);
	import nrd_pkg::*;

	logic [WIDTH:0]   vld_p;
	logic [WIDTH:0]   rdy_p;
	logic [WIDTH-1:0] acc_p [0:WIDTH];
	logic [WIDTH-1:0] quo_p [0:WIDTH];
	logic [WIDTH-1:0] dsr_p [0:WIDTH];

	assign vld_p[0]  = req.valid;
	assign acc_p[0]  = '0;
	assign quo_p[0]  = req.dividend;
	assign dsr_p[0]  = req.divisor;
	assign req.ready = rdy_p[0];

	for (genvar k = 0; k < WIDTH; k++) begin : g_step
		nrd_step #(
			.WIDTH(WIDTH)
		) u_step (
			.clk      (clk),
			.arst_n   (arst_n),
			.valid_in (vld_p[k]),
			.ready_up (rdy_p[k]),
			.acc_in   (acc_p[k]),
			.quo_in   (quo_p[k]),
			.dsr_in   (dsr_p[k]),
			.valid_s1 (vld_p[k+1]),
			.ready_dn (rdy_p[k+1]),
			.acc_s1   (acc_p[k+1]),
			.quo_s1   (quo_p[k+1]),
			.dsr_s1   (dsr_p[k+1])
		);
	end

	nrd_fix #(
		.WIDTH(WIDTH)
	) u_fix (
		.clk      (clk),
		.arst_n   (arst_n),
		.valid_in (vld_p[WIDTH]),
		.ready_up (rdy_p[WIDTH]),
		.acc_in   (acc_p[WIDTH]),
		.quo_in   (quo_p[WIDTH]),
		.dsr_in   (dsr_p[WIDTH]),
		.rsp      (rsp)
	);

`ifndef SYNTHESIS
	// back-pressure reaches the input only with a full pipeline and a stalled result
	a_full_when_blocked: assert property (@(posedge clk) disable iff (!arst_n)
		!req.ready |-> ((&vld_p[WIDTH:1]) && rsp.valid && !rsp.ready))
		else $error("req.ready low while the pipeline has room");

	a_enter_first: assert property (@(posedge clk) disable iff (!arst_n)
		(req.valid && req.ready) |=> vld_p[1])
		else $error("accepted operands did not reach the first stage");

	a_last_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(vld_p[WIDTH] && !rdy_p[WIDTH]) |=> (vld_p[WIDTH] && $stable(quo_p[WIDTH])
			&& $stable(acc_p[WIDTH])))
		else $error("last step lost its item while the fix stage was stalled");
`endif

endmodule : nonrestoring_divider_16

`default_nettype wire

[hw/rtl/nrd_step.sv]
// One registered step of the non-restoring recurrence.
// Uses nrd_pkg; instantiated WIDTH times by nonrestoring_divider_16.
`default_nettype none

module nrd_step #(
	parameter int WIDTH = nrd_pkg::NRD_WIDTH
) (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             valid_in,
	output logic                  ready_up,
	input  wire logic [WIDTH-1:0] acc_in,
	input  wire logic [WIDTH-1:0] quo_in,
	input  wire logic [WIDTH-1:0] dsr_in,
	output logic                  valid_s1,
	input  wire logic             ready_dn,
	output logic      [WIDTH-1:0] acc_s1,
	output logic      [WIDTH-1:0] quo_s1,
	output logic      [WIDTH-1:0] dsr_s1
);
	import nrd_pkg::*;

	logic             old_neg;
	logic [WIDTH-1:0] acc_sh;
	logic [WIDTH-1:0] addend;
	logic [WIDTH-1:0] acc_nxt;
	logic [WIDTH-1:0] quo_nxt;

	always_comb begin
		old_neg = acc_in[WIDTH-1];
		// shift the next dividend bit into the accumulator
		acc_sh  = {acc_in[WIDTH-2:0], quo_in[WIDTH-1]};
		// a zero accumulator always takes the subtract path
		if (old_neg && (acc_sh != '0)) begin
			addend = dsr_in;
		end else begin
			addend = (~dsr_in) + {{(WIDTH-1){1'b0}}, 1'b1};
		end
		acc_nxt = acc_sh + addend;
		quo_nxt = {quo_in[WIDTH-2:0], ~acc_nxt[WIDTH-1]};
	end

	assign ready_up = !valid_s1 || ready_dn;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (ready_up) begin
			valid_s1 <= valid_in;
		end
	end

	// advance the payload only on a transfer into this stage
	always_ff @(posedge clk) begin
		if (ready_up && valid_in) begin
			acc_s1 <= acc_nxt;
			quo_s1 <= quo_nxt;
			dsr_s1 <= dsr_in;
		end
	end

endmodule : nrd_step

`default_nettype wire

[hw/rtl/nrd_fix.sv]
// Final stage: corrective add of the divisor and the result register.
// Uses nrd_pkg and the nrd_out_if interface.
`default_nettype none

module nrd_fix #(
	parameter int WIDTH = nrd_pkg::NRD_WIDTH
) (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             valid_in,
	output logic                  ready_up,
	input  wire logic [WIDTH-1:0] acc_in,
	input  wire logic [WIDTH-1:0] quo_in,
	input  wire logic [WIDTH-1:0] dsr_in,
	nrd_out_if.source             rsp
);
	import nrd_pkg::*;

	logic             valid_q;
	logic [WIDTH-1:0] quo_q;
	logic [WIDTH-1:0] rem_q;
	logic [WIDTH-1:0] rem_nxt;

	// restore a negative accumulator
	assign rem_nxt  = acc_in[WIDTH-1] ? (acc_in + dsr_in) : acc_in;
	assign ready_up = !valid_q || rsp.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (ready_up) begin
			valid_q <= valid_in;
		end
	end

	always_ff @(posedge clk) begin
		if (ready_up && valid_in) begin
			quo_q <= quo_in;
			rem_q <= rem_nxt;
		end
	end

	assign rsp.valid     = valid_q;
	assign rsp.quotient  = quo_q;
	assign rsp.remainder = rem_q;

endmodule : nrd_fix

`default_nettype wire

[tb/sv/tb.sv]
// Self-checking testbench for nonrestoring_divider_16: operand pairs in, quotient/remainder out.
// Depends on nrd_pkg, nrd_if (nrd_in_if, nrd_out_if) and the divider top level.
`default_nettype none

module tb;

	localparam int W = nrd_pkg::NRD_WIDTH;

	typedef logic [W-1:0] word_t;

	typedef struct {
		word_t       dividend;
		word_t       divisor;
		int unsigned gap;
		bit          drain;
	} operand_t;

	typedef struct {
		word_t dividend;
		word_t divisor;
		word_t quotient;
		word_t remainder;
	} division_t;

	logic clk = 1'b0;
	logic arst_n;

	nrd_in_if  req_ch ();
	nrd_out_if rsp_ch ();

	nonrestoring_divider_16 dut (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req_ch),
		.rsp    (rsp_ch)
	);

	operand_t    pending_ops[$];
	division_t   expected_div[$];
	operand_t    next_op;
	division_t   want;
	int unsigned accepted  = 0;
	int unsigned delivered = 0;
	int unsigned err_cnt   = 0;
	int unsigned idle_cnt  = 0;
	int unsigned stall_cnt = 0;
	logic        hold_rx   = 1'b0;

	always #10 clk = ~clk;

	// Bit-accurate non-restoring recurrence with the final corrective add.
	function automatic division_t divide_nonrestoring(input word_t dividend, input word_t divisor);
		division_t res;
		word_t     acc;
		word_t     quo;
		word_t     neg_div;
		word_t     addend;
		logic      was_neg;
		acc     = '0;
		quo     = dividend;
		neg_div = -divisor;
		for (int k = 0; k < W; k++) begin
			was_neg = acc[W-1];
			acc     = {acc[W-2:0], quo[W-1]};
			addend  = was_neg ? divisor : neg_div;
			// a zero shifted accumulator always subtracts
			if (acc == '0) begin
				addend = neg_div;
			end
			acc = acc + addend;
			quo = {quo[W-2:0], ~acc[W-1]};
		end
		if (acc[W-1]) begin
			acc = acc + divisor;
		end
		res.dividend  = dividend;
		res.divisor   = divisor;
		res.quotient  = quo;
		res.remainder = acc;
		return res;
	endfunction

	task automatic report(input string msg);
		$display("MISMATCH @%0t: %s", $time, msg);
		err_cnt++;
	endtask

	task automatic add_op(input word_t dividend, input word_t divisor, input int unsigned gap,
			input bit drain);
		operand_t op;
		op.dividend = dividend;
		op.divisor  = divisor;
		op.gap      = gap;
		op.drain    = drain;
		pending_ops.push_back(op);
	endtask

	// Driver: record each transfer, then offer the next pair after its idle gap.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			req_ch.valid    <= 1'b0;
			req_ch.dividend <= '0;
			req_ch.divisor  <= '0;
			idle_cnt = 0;
		end else begin
			if (req_ch.valid && req_ch.ready) begin
				expected_div.push_back(divide_nonrestoring(req_ch.dividend, req_ch.divisor));
				accepted++;
			end
			if (!req_ch.valid || req_ch.ready) begin
				if (pending_ops.size() == 0) begin
					req_ch.valid <= 1'b0;
				end else if (idle_cnt < pending_ops[0].gap) begin
					idle_cnt++;
					req_ch.valid <= 1'b0;
				end else if (pending_ops[0].drain && expected_div.size() != 0) begin
					// hold until the pipeline has emptied
					req_ch.valid <= 1'b0;
				end else begin
					next_op = pending_ops.pop_front();
					req_ch.dividend <= next_op.dividend;
					req_ch.divisor  <= next_op.divisor;
					req_ch.valid    <= 1'b1;
					idle_cnt = 0;
				end
			end
		end
	end

	// Monitor: check each result transfer against the oldest expectation.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_ch.ready <= 1'b0;
			stall_cnt = 0;
		end else begin
			if (rsp_ch.valid && rsp_ch.ready) begin
				if (expected_div.size() == 0) begin
					report($sformatf("unexpected result q=%h r=%h",
						rsp_ch.quotient, rsp_ch.remainder));
				end else begin
					want = expected_div.pop_front();
					if (rsp_ch.quotient !== want.quotient)
						report($sformatf("%h / %h quotient got %h want %h", want.dividend,
							want.divisor, rsp_ch.quotient, want.quotient));
					if (rsp_ch.remainder !== want.remainder)
						report($sformatf("%h / %h remainder got %h want %h", want.dividend,
							want.divisor, rsp_ch.remainder, want.remainder));
				end
				delivered++;
				stall_cnt = ((delivered / 80) % 3 == 1) ? 0 : $urandom_range(0, 12);
			end else if (stall_cnt != 0) begin
				stall_cnt--;
			end
			rsp_ch.ready <= !hold_rx && stall_cnt == 0;
		end
	end

	// Long receiver hold-off while the sender streams back to back.
	initial begin
		wait (accepted >= 320);
		@(posedge clk);
		hold_rx <= 1'b1;
		repeat (100) @(posedge clk);
		hold_rx <= 1'b0;
	end

	initial begin
		#4000000;
		$display("nonrestoring_divider_16 regression: fail");
		$finish;
	end

	initial begin
		int unsigned kind;
		int unsigned gap;
		int unsigned k;
		word_t       a;
		word_t       b;
		word_t       picks[5];

		arst_n          = 1'b0;
		req_ch.valid    = 1'b0;
		req_ch.dividend = '0;
		req_ch.divisor  = '0;
		rsp_ch.ready    = 1'b0;
		picks = '{16'h0000, 16'h0001, 16'h7fff, 16'h8000, 16'hffff};

		// directed: extremes, zero divisor, exact multiples, alternating patterns
		add_op(16'h0000, 16'h0000, 0, 1'b0);
		add_op(16'hffff, 16'hffff, 0, 1'b0);
		add_op(16'hffff, 16'h0000, 0, 1'b0);
		add_op(16'h1234, 16'h0000, 3, 1'b0);
		add_op(16'h0000, 16'hffff, 0, 1'b0);
		add_op(16'hffff, 16'h0001, 0, 1'b0);
		add_op(16'h0001, 16'hffff, 1, 1'b0);
		add_op(16'h8000, 16'h8000, 0, 1'b0);
		add_op(16'h7fff, 16'h8000, 0, 1'b0);
		add_op(16'h8000, 16'h0001, 2, 1'b0);
		add_op(16'h7fff, 16'h7fff, 0, 1'b0);
		add_op(16'h0006, 16'h0003, 0, 1'b0);
		add_op(16'h0064, 16'h0007, 0, 1'b0);
		add_op(16'h0007, 16'h0064, 5, 1'b0);
		add_op(16'haaaa, 16'h5555, 0, 1'b0);
		add_op(16'h5555, 16'haaaa, 0, 1'b0);
		add_op(16'hffff, 16'h0002, 0, 1'b0);
		add_op(16'hffff, 16'h8000, 0, 1'b0);
		add_op(16'h0001, 16'h0001, 0, 1'b0);
		add_op(16'hf000, 16'h0010, 0, 1'b0);

		for (int i = 0; i < 930; i++) begin
			kind = $urandom_range(0, 7);
			a = word_t'($urandom);
			b = word_t'($urandom);
			case (kind)
				4: begin
					b = word_t'($urandom_range(1, 15));
				end
				5: begin
					b = word_t'(1) << $urandom_range(0, W - 1);
					if ($urandom_range(0, 1)) b = ~b;
				end
				6: begin
					// exact multiple drives the accumulator through zero
					b = word_t'($urandom_range(1, 255));
					k = $urandom_range(0, 65535 / b);
					a = word_t'(b * k);
				end
				7: begin
					if ($urandom_range(0, 1)) a = picks[$urandom_range(0, 4)];
					if ($urandom_range(0, 1)) b = picks[$urandom_range(0, 4)];
				end
				default: begin
				end
			endcase
			if ((i / 60) % 3 == 0 || (i >= 280 && i < 460))
				gap = 0;
			else
				gap = $urandom_range(0, 12);
			add_op(a, b, gap, i == 0 || i == 500 || i == 800);
		end

		repeat (11) @(posedge clk);
		arst_n <= 1'b1;

		while (pending_ops.size() != 0 || req_ch.valid || expected_div.size() != 0)
			@(posedge clk);
		repeat (40) @(posedge clk);

		if (err_cnt == 0)
			$display("nonrestoring_divider_16 regression: pass");
		else
			$display("nonrestoring_divider_16 regression: fail");
		$finish;
	end

endmodule : tb

`default_nettype wire
